/* design/wildcard_glob_match_defines.svh */
// assertion macros used by the checker file
`ifndef WILDCARD_GLOB_MATCH_DEFINES_SVH
`define WILDCARD_GLOB_MATCH_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WGM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define WGM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wgm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

    localparam int MAX_MASK = 32;
    localparam int LEN_W    = $clog2(MAX_MASK + 1);
    localparam int IDX_W    = (MAX_MASK > 1) ? $clog2(MAX_MASK) : 1;
    localparam int ACT_W    = MAX_MASK + 1;
    localparam int PADDR_W  = 2;

    localparam logic [ACT_W-1:0]   ACT_RESTART      = ACT_W'(1);
    localparam logic [PADDR_W-1:0] ADDR_IGNORE_CASE = PADDR_W'(0);

    localparam logic [7:0] STAR_CODE = 8'h2A;
    localparam logic [7:0] ANY_CODE  = 8'h3F;
    localparam logic [7:0] LOWER_A   = 8'h61;
    localparam logic [7:0] LOWER_Z   = 8'h7A;
    localparam logic [7:0] UPPER_A   = 8'h41;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_NAME   = 2'd2,
        OP_END    = 2'd3
    } op_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && (c inside {[LOWER_A:LOWER_Z]}))
        begin
            r = c - LOWER_A + UPPER_A;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/wildcard_glob_match.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake            | payload
// --------+----------------------+---------------------------
// in      | in_valid / in_stall  | opcode, char_code
// out     | out_valid / out_stall| matched, mask_overflow
// cfg     | apb write/read       | ignore_case at offset 0
//
// one transaction per cycle unless in_stall; result via input and result registers
// the rate is set by the active-position update on the registered item
// rst_n clears mask length, flags and both valids, and restarts active positions
// in_stall rises only when an end-of-name waits behind a stalled result

module wildcard_glob_match
    import wgm_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,

    input  wire                 in_valid,
    output logic                in_stall,
    input  wire  [1:0]          opcode,
    input  wire  [7:0]          char_code,

    output logic                out_valid,
    input  wire                 out_stall,
    output logic                matched,
    output logic                mask_overflow,

    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [PADDR_W-1:0]  paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic              ignore_case_reg;

    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [7:0]        s1_char_reg;

    logic [7:0]        mask_reg [MAX_MASK];
    logic [LEN_W-1:0]  len_reg;
    logic [ACT_W-1:0]  act_reg;
    logic              prev_star_reg;
    logic              ovf_reg;

    logic              out_valid_reg;
    logic              matched_reg;
    logic              ovf_out_reg;

    logic [MAX_MASK-1:0] lane_valid;
    logic [MAX_MASK-1:0] lane_star;
    logic [MAX_MASK-1:0] lane_hit;
    logic [ACT_W-1:0]    closed;
    logic [ACT_W-1:0]    step_next;
    logic [7:0]          name_fold;
    logic                s1_go;
    logic                s1_is_star;
    logic                cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_IGNORE_CASE);
    assign prdata    = (paddr == ADDR_IGNORE_CASE) ? {31'b0, ignore_case_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_case_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            ignore_case_reg <= pwdata[0];
        end
    end

    // per-position lanes
    assign name_fold = fold_char(s1_char_reg, ignore_case_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_MASK; i++)
        begin
            lane_valid[i] = (LEN_W'(i) < len_reg);
            lane_star[i]  = lane_valid[i] && (mask_reg[i] == STAR_CODE);
            lane_hit[i]   = lane_valid[i] && !lane_star[i] &&
                            ((mask_reg[i] == ANY_CODE) ||
                             (fold_char(mask_reg[i], ignore_case_reg) == name_fold));
        end
    end

    // stored stars never sit next to each other, so one step of closure suffices
    assign closed = act_reg | {lane_star & act_reg[MAX_MASK-1:0], 1'b0};

    always_comb
    begin
        step_next = '0;
        for (int i = 0; i < MAX_MASK; i++)
        begin
            if (closed[i] && lane_star[i])
            begin
                step_next[i] = 1'b1;
            end
            if (closed[i] && lane_hit[i])
            begin
                step_next[i+1] = 1'b1;
            end
        end
    end

    // input register
    assign s1_go      = s1_valid_reg && ((s1_op_reg != OP_END) || !out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_go;
    assign s1_is_star = (s1_char_reg == STAR_CODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_op_reg   <= op_t'(opcode);
            s1_char_reg <= char_code;
        end
    end

    // mask storage
    always_ff @(posedge clk)
    begin
        if (s1_go && (s1_op_reg == OP_APPEND) && !(s1_is_star && prev_star_reg) &&
            (len_reg < LEN_W'(MAX_MASK)))
        begin
            mask_reg[len_reg[IDX_W-1:0]] <= s1_char_reg;
        end
    end

    // matcher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            act_reg       <= ACT_RESTART;
            prev_star_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else if (s1_go)
        begin
            case (s1_op_reg)
                OP_CLEAR:
                begin
                    len_reg       <= '0;
                    act_reg       <= ACT_RESTART;
                    prev_star_reg <= 1'b0;
                    ovf_reg       <= 1'b0;
                end
                OP_APPEND:
                begin
                    if (!(s1_is_star && prev_star_reg))
                    begin
                        if (len_reg < LEN_W'(MAX_MASK))
                        begin
                            len_reg <= len_reg + LEN_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    prev_star_reg <= s1_is_star;
                    act_reg       <= ACT_RESTART;
                end
                OP_NAME:
                begin
                    act_reg <= step_next;
                end
                OP_END:
                begin
                    act_reg <= ACT_RESTART;
                end
                default:
                begin
                    act_reg <= ACT_RESTART;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && (s1_op_reg == OP_END))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && (s1_op_reg == OP_END))
        begin
            matched_reg <= closed[len_reg];
            ovf_out_reg <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign matched       = matched_reg;
    assign mask_overflow = ovf_out_reg;

endmodule

`default_nettype wire

/* design/wgm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "wildcard_glob_match_defines.svh"

module wgm_checker
    import wgm_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_stall,
    input wire [1:0]          opcode,
    input wire                out_valid,
    input wire                out_stall,
    input wire                matched,
    input wire                mask_overflow
);

    logic in_take;
    logic end_take;
    logic clear_take;

    assign in_take    = in_valid && !in_stall;
    assign end_take   = in_take && (opcode == OP_END);
    assign clear_take = in_take && (opcode == OP_CLEAR);

    // a stalled result holds
    `WGM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(matched) && $stable(mask_overflow), "result changed under stall")

    // input backs up only behind a stalled result
    `WGM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
        "input stalled with free result slot")

    // a fresh result comes from an end-of-name transaction taken through the input register and the result register
    `WGM_ASSERT_NOW(a_result_src, $rose(out_valid), $past(end_take, 2),
        "result without end-of-name transaction")

    // empty mask matches empty name with no overflow
    `WGM_ASSERT_NOW(a_empty_match, $rose(out_valid) && $past(end_take, 2) && $past(clear_take, 3),
        matched && !mask_overflow, "empty mask did not match empty name")

endmodule

bind wildcard_glob_match wgm_checker u_wgm_checker (.*);

`default_nettype wire
